/* rtl/core/minimap_raster_blend_engine_core_defines.svh */
// assertion macros for the raster blend engine core
`ifndef MINIMAP_RASTER_BLEND_ENGINE_CORE_DEFINES_SVH
`define MINIMAP_RASTER_BLEND_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define MRBE_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("raster core assertion failed");

// next-cycle implication
`define MRBE_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("raster core assertion failed");

`endif

/* rtl/core/mrbe_pkg.sv */
// shared constants and word types of the raster blend engine
package mrbe_pkg;

    localparam int MAP_DIM   = 128;
    localparam int MAP_LOG   = $clog2(MAP_DIM);
    localparam int ADDR_W    = 2 * MAP_LOG;
    localparam int FB_DEPTH  = MAP_DIM * MAP_DIM;
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int FRAC_BITS = 16;
    localparam int CRD_W     = 12;
    localparam int DIF_W     = CRD_W + 1;
    localparam int ACC_W     = 48;
    localparam int INT_W     = ACC_W - FRAC_BITS;
    localparam int DIV_W     = DIF_W + FRAC_BITS;
    localparam int Q_W       = DIV_W + 1;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int REACH_W   = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CH_W-1:0]    CH_MAX   = 8'hFF;
    localparam logic [CH_W-1:0]    SAT_RST  = 8'd255;
    localparam logic [PADDR_W-1:0] ADDR_SAT = 3'd0;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_POINT = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_TRI   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [CRD_W-1:0] ax;
        logic signed [CRD_W-1:0] ay;
        logic signed [CRD_W-1:0] bx;
        logic signed [CRD_W-1:0] by;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [REACH_W-1:0]      reach_sq;
        logic [CH_W-1:0]         mark_id;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] read_red;
        logic [CH_W-1:0] read_green;
        logic [CH_W-1:0] read_blue;
        logic [CH_W-1:0] read_mark;
        logic            op_done;
    } t_out_word;

endpackage

/* rtl/core/mrbe_ifs.sv */
// valid/ready channel interfaces for command and result words
interface mrbe_in_if;
    logic                valid;
    logic                ready;
    mrbe_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mrbe_out_if;
    logic                valid;
    logic                ready;
    mrbe_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/mrbe_ram.sv */
// generic single-write, registered-read ram
module mrbe_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/core/mrbe_div.sv */
// iterative restoring fixed-point divider, one quotient bit per cycle
module mrbe_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [mrbe_pkg::DIF_W-1:0] i_num,
    input  logic signed [mrbe_pkg::DIF_W-1:0] i_den,
    output logic                             o_done,
    output logic signed [mrbe_pkg::Q_W-1:0]   o_quo
);
    import mrbe_pkg::*;

    logic             r_busy, n_busy, r_done, n_done;
    logic             r_neg, n_neg, r_zero, n_zero;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIF_W-1:0] r_rem, n_rem, r_den, n_den;
    logic [DIV_W-1:0] r_q, n_q;
    logic [DIF_W:0]   sh;
    logic             ge;
    logic [DIF_W-1:0] nmag, dmag;

    always_comb begin
        nmag   = i_num[DIF_W-1] ? DIF_W'(-i_num) : DIF_W'(i_num);
        dmag   = i_den[DIF_W-1] ? DIF_W'(-i_den) : DIF_W'(i_den);
        sh     = {r_rem, r_q[DIV_W-1]};
        ge     = sh >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
            n_rem  = '0;
            n_q    = {nmag, {FRAC_BITS{1'b0}}};
            n_den  = dmag;
            n_neg  = i_num[DIF_W-1] ^ i_den[DIF_W-1];
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            n_rem = ge ? DIF_W'(sh - {1'b0, r_den}) : sh[DIF_W-1:0];
            n_q   = {r_q[DIV_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 :
                    (r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q}));
endmodule

/* rtl/core/minimap_raster_blend_engine_core.sv */
// raster blend engine top: sequencer, shared divider, framebuffer and config port
//
//  channel | dir | handshake           | word
//  i_in    | in  | valid/ready         | op, vertices, reach_sq, mark_id, color
//  o_out   | out | valid/ready         | read color, read mark, op_done
//  apb     | in  | psel/penable/pready | saturation_limit at offset 0
//
// reset runs a clearing pass through the framebuffer; no word is taken then
// clear: one pass over every framebuffer word; point: one read-modify-write; read: one ram read
// line: one divider run for the slope, then one read-modify-write per pixel of the major axis
// triangle: three divider runs, a step per row, and a read-modify-write per span pixel checked on map rows
// a finished result waits in the output register; the next word is taken meanwhile
`include "minimap_raster_blend_engine_core_defines.svh"
module minimap_raster_blend_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mrbe_in_if.sink                        i_in,
    mrbe_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrbe_pkg::PADDR_W-1:0]   paddr,
    input  logic [mrbe_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrbe_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import mrbe_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_CLR  = 12'b000000000010,
        S_DIV  = 12'b000000000100,
        S_DIVW = 12'b000000001000,
        S_LPIX = 12'b000000010000,
        S_LWR  = 12'b000000100000,
        S_TROW = 12'b000001000000,
        S_TPIX = 12'b000010000000,
        S_TWR  = 12'b000100000000,
        S_RD   = 12'b001000000000,
        S_RDW  = 12'b010000000000,
        S_FIN  = 12'b100000000000
    } t_state;

    function automatic logic signed [INT_W-1:0] fx_trunc(input logic signed [ACC_W-1:0] v);
        logic signed [INT_W-1:0] fl;
        fl = v[ACC_W-1:FRAC_BITS];
        if (v[ACC_W-1] && (v[FRAC_BITS-1:0] != '0)) begin
            fl = fl + INT_W'(1);
        end
        return fl;
    endfunction

    function automatic logic signed [ACC_W-1:0] to_fx(input logic signed [DIF_W-1:0] v);
        return ACC_W'(v) <<< FRAC_BITS;
    endfunction

    function automatic logic on_map(input logic signed [INT_W-1:0] v);
        return (v >= 0) && (v < $signed(INT_W'(MAP_DIM)));
    endfunction

    function automatic logic [CH_W-1:0] add_sat(input logic [CH_W-1:0] cur,
                                                input logic [CH_W-1:0] inc,
                                                input logic [CH_W-1:0] lim);
        logic [CH_W:0] t;
        t = {1'b0, cur} + {1'b0, inc};
        return (t > {1'b0, lim}) ? lim : t[CH_W-1:0];
    endfunction

    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_clr, n_clr;
    logic                      r_clr_op, n_clr_op;
    logic                      r_ov, n_ov;
    logic [CH_W-1:0]           r_sat;
    t_out_word                 r_out, n_out, r_res, n_res;
    logic [2:0]                r_op, n_op;
    logic [CH_W-1:0]           r_id, n_id, r_cr, n_cr, r_cg, n_cg, r_cb, n_cb;
    logic [REACH_W-1:0]        r_reach, n_reach;
    logic signed [CRD_W-1:0]   r_mx, n_mx, r_my, n_my;
    logic signed [CRD_W-1:0]   r_x1, n_x1, r_y1, n_y1, r_x2, n_x2;
    logic signed [CRD_W-1:0]   r_y2, n_y2, r_x3, n_x3, r_y3, n_y3;
    logic signed [Q_W-1:0]     r_d1, n_d1, r_d2, n_d2, r_d3, n_d3;
    logic [1:0]                r_dsel, n_dsel;
    logic signed [DIF_W-1:0]   r_dnum, n_dnum, r_dden, n_dden;
    logic signed [DIF_W-1:0]   r_maj, n_maj, r_end, n_end, r_row, n_row;
    logic                      r_xmaj, n_xmaj, r_part, n_part, r_keep, n_keep;
    logic signed [ACC_W-1:0]   r_acc, n_acc, r_xa, n_xa, r_xb, n_xb, r_hi, n_hi;
    logic [MAP_LOG:0]          r_x, n_x;
    logic [ADDR_W-1:0]         r_addr, n_addr;

    logic                      div_start, div_done;
    logic signed [DIF_W-1:0]   div_num, div_den;
    logic signed [Q_W-1:0]     div_quo;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [PIX_W-1:0]          ram_wdata, ram_rdata;
    logic                      in_acc, cfg_wr;

    t_in_word                  w;
    logic signed [CRD_W-1:0]   p1x, p1y, p2x, p2y, p3x, p3y, tx, ty;
    logic signed [DIF_W-1:0]   l_dx, l_dy, l_ms, l_ns, l_end;
    logic [DIF_W-1:0]          l_adx, l_ady;
    logic                      l_xmaj, l_swap, l_deg;
    logic signed [ACC_W-1:0]   d1e, d2e, d3e, nxa, nxb, lo, hi;
    logic signed [DIF_W-1:0]   row_end, ddx, ddy;
    logic signed [2*DIF_W-1:0] sqx, sqy;
    logic [2*DIF_W:0]          dsq;
    logic signed [INT_W-1:0]   tlo, mi, maj32, px, py, rx32, ry32;
    logic signed [ACC_W-1:0]   xfx;
    logic                      lo_first, pix_on;
    logic [CH_W-1:0]           c_r, c_g, c_b, c_m;

    assign w       = i_in.data;
    assign in_acc  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_SAT) ? PDATA_W'(r_sat) : '0;

    always_comb begin
        // triangle vertex sort by y
        p1x = w.ax; p1y = w.ay; p2x = w.bx; p2y = w.by; p3x = w.cx; p3y = w.cy;
        tx = '0; ty = '0;
        if (p1y > p2y) begin
            tx = p1x; ty = p1y; p1x = p2x; p1y = p2y; p2x = tx; p2y = ty;
        end
        if (p1y > p3y) begin
            tx = p1x; ty = p1y; p1x = p3x; p1y = p3y; p3x = tx; p3y = ty;
        end
        if (p2y > p3y) begin
            tx = p2x; ty = p2y; p2x = p3x; p2y = p3y; p3x = tx; p3y = ty;
        end

        // line setup
        l_dx   = DIF_W'(w.ax) - DIF_W'(w.bx);
        l_dy   = DIF_W'(w.ay) - DIF_W'(w.by);
        l_adx  = l_dx[DIF_W-1] ? DIF_W'(-l_dx) : DIF_W'(l_dx);
        l_ady  = l_dy[DIF_W-1] ? DIF_W'(-l_dy) : DIF_W'(l_dy);
        l_xmaj = l_adx > l_ady;
        l_deg  = (l_dx == '0) && (l_dy == '0);
        if (l_xmaj) begin
            l_swap = w.ax > w.bx;
            l_ms   = DIF_W'(l_swap ? w.bx : w.ax);
            l_ns   = DIF_W'(l_swap ? w.by : w.ay);
            l_end  = DIF_W'(l_swap ? w.ax : w.bx);
        end else begin
            l_swap = w.ay > w.by;
            l_ms   = DIF_W'(l_swap ? w.by : w.ay);
            l_ns   = DIF_W'(l_swap ? w.bx : w.ax);
            l_end  = DIF_W'(l_swap ? w.ay : w.by);
        end

        // divider operands
        if (r_op == OP_LINE) begin
            div_num = r_dnum;
            div_den = r_dden;
        end else begin
            case (r_dsel)
                2'd0: begin
                    div_num = DIF_W'(r_x1) - DIF_W'(r_x3);
                    div_den = DIF_W'(r_y1) - DIF_W'(r_y3);
                end
                2'd1: begin
                    div_num = DIF_W'(r_x2) - DIF_W'(r_x1);
                    div_den = DIF_W'(r_y2) - DIF_W'(r_y1);
                end
                default: begin
                    div_num = DIF_W'(r_x3) - DIF_W'(r_x2);
                    div_den = DIF_W'(r_y3) - DIF_W'(r_y2);
                end
            endcase
        end

        // row stepping
        d1e      = ACC_W'(r_d1);
        d2e      = ACC_W'(r_d2);
        d3e      = ACC_W'(r_d3);
        row_end  = r_part ? DIF_W'(r_y3) : DIF_W'(r_y2);
        nxa      = r_xa + d1e;
        nxb      = r_xb + (r_part ? d3e : d2e);
        lo_first = r_part ? (r_d3 < r_d1) : (r_d1 < r_d2);
        lo       = lo_first ? nxa : nxb;
        hi       = lo_first ? nxb : nxa;
        tlo      = fx_trunc(lo);

        // span pixel
        xfx  = $signed(ACC_W'({r_x, {FRAC_BITS{1'b0}}}));
        ddx  = $signed(DIF_W'(r_x)) - DIF_W'(r_mx);
        ddy  = r_row - DIF_W'(r_my);
        sqx  = ddx * ddx;
        sqy  = ddy * ddy;
        dsq  = {1'b0, sqx} + {1'b0, sqy};

        // line pixel
        mi    = fx_trunc(r_acc);
        maj32 = INT_W'(r_maj);
        px    = r_xmaj ? maj32 : mi;
        py    = r_xmaj ? mi : maj32;
        pix_on = on_map(px) && on_map(py);
        rx32  = INT_W'(w.ax);
        ry32  = INT_W'(w.ay);

        c_r = ram_rdata[7:0];
        c_g = ram_rdata[15:8];
        c_b = ram_rdata[23:16];
        c_m = ram_rdata[31:24];
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;     n_clr_op = r_clr_op; n_ov = r_ov;
        n_out = r_out;     n_res = r_res;      n_op = r_op;
        n_id = r_id;       n_cr = r_cr;        n_cg = r_cg;   n_cb = r_cb;
        n_reach = r_reach; n_mx = r_mx;        n_my = r_my;
        n_x1 = r_x1; n_y1 = r_y1; n_x2 = r_x2; n_y2 = r_y2; n_x3 = r_x3; n_y3 = r_y3;
        n_d1 = r_d1; n_d2 = r_d2; n_d3 = r_d3; n_dsel = r_dsel;
        n_dnum = r_dnum; n_dden = r_dden;
        n_maj = r_maj; n_end = r_end; n_row = r_row;
        n_xmaj = r_xmaj; n_part = r_part; n_keep = r_keep;
        n_acc = r_acc; n_xa = r_xa; n_xb = r_xb; n_hi = r_hi;
        n_x = r_x; n_addr = r_addr;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op = w.op; n_id = w.mark_id; n_reach = w.reach_sq;
                    n_cr = w.red; n_cg = w.green; n_cb = w.blue;
                    n_mx = w.ax; n_my = w.ay;
                    n_x1 = p1x; n_y1 = p1y; n_x2 = p2x; n_y2 = p2y; n_x3 = p3x; n_y3 = p3y;
                    n_dsel = 2'd0;
                    n_res = '0;
                    n_res.op_done = (w.op <= OP_READ);
                    unique case (w.op)
                        OP_CLEAR: begin
                            n_clr = '0;
                            n_clr_op = 1'b1;
                            n_state = S_CLR;
                        end
                        OP_POINT, OP_LINE: begin
                            if (w.op == OP_POINT || l_deg) begin
                                n_maj  = DIF_W'(w.ax);
                                n_end  = DIF_W'(w.ax) + DIF_W'(1);
                                n_acc  = to_fx(DIF_W'(w.ay));
                                n_xmaj = 1'b1;
                                n_d1   = '0;
                                n_state = S_LPIX;
                            end else begin
                                n_maj  = l_ms;
                                n_end  = l_end;
                                n_acc  = to_fx(l_ns);
                                n_xmaj = l_xmaj;
                                n_dnum = l_xmaj ? l_dy : l_dx;
                                n_dden = l_xmaj ? l_dx : l_dy;
                                n_state = S_DIV;
                            end
                        end
                        OP_TRI: begin
                            n_state = S_DIV;
                        end
                        OP_READ: begin
                            n_keep = on_map(rx32) && on_map(ry32);
                            n_addr = {w.ay[MAP_LOG-1:0], w.ax[MAP_LOG-1:0]};
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_clr_op = 1'b0;
                    n_state  = r_clr_op ? S_FIN : S_IDLE;
                end
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    if (r_op == OP_LINE) begin
                        n_d1    = div_quo;
                        n_state = S_LPIX;
                    end else begin
                        case (r_dsel)
                            2'd0:    n_d1 = div_quo;
                            2'd1:    n_d2 = div_quo;
                            default: n_d3 = div_quo;
                        endcase
                        if (r_dsel == 2'd2) begin
                            n_xa = to_fx(DIF_W'(r_x1));
                            if (r_y1 == r_y2) begin
                                n_xb   = to_fx(DIF_W'(r_x2));
                                n_part = 1'b1;
                            end else begin
                                n_xb   = to_fx(DIF_W'(r_x1));
                                n_part = 1'b0;
                            end
                            n_row   = DIF_W'(r_y1);
                            n_state = S_TROW;
                        end else begin
                            n_dsel  = r_dsel + 2'd1;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_LPIX: begin
                if (r_maj == r_end) begin
                    n_state = S_FIN;
                end else begin
                    n_keep    = pix_on;
                    n_addr    = {py[MAP_LOG-1:0], px[MAP_LOG-1:0]};
                    ram_raddr = n_addr;
                    n_state   = S_LWR;
                end
            end
            S_LWR: begin
                ram_we    = r_keep;
                ram_wdata = {c_m, add_sat(c_b, r_cb, CH_MAX), add_sat(c_g, r_cg, CH_MAX),
                             add_sat(c_r, r_cr, CH_MAX)};
                n_maj   = r_maj + DIF_W'(1);
                n_acc   = r_acc + d1e;
                n_state = S_LPIX;
            end
            S_TROW: begin
                if (r_row == row_end) begin
                    if (!r_part) begin
                        n_part = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_xa = nxa;
                    n_xb = nxb;
                    if (r_row >= 0 && r_row < $signed(DIF_W'(MAP_DIM))) begin
                        n_hi = hi;
                        if (tlo < 0) begin
                            n_x = '0;
                        end else if (tlo >= $signed(INT_W'(MAP_DIM))) begin
                            n_x = (MAP_LOG+1)'(MAP_DIM);
                        end else begin
                            n_x = tlo[MAP_LOG:0];
                        end
                        n_state = S_TPIX;
                    end else begin
                        n_row = r_row + DIF_W'(1);
                    end
                end
            end
            S_TPIX: begin
                if (r_x[MAP_LOG] || !(xfx < r_hi)) begin
                    n_row   = r_row + DIF_W'(1);
                    n_state = S_TROW;
                end else begin
                    n_keep    = dsq <= (2*DIF_W+1)'(r_reach);
                    n_addr    = {r_row[MAP_LOG-1:0], r_x[MAP_LOG-1:0]};
                    ram_raddr = n_addr;
                    n_state   = S_TWR;
                end
            end
            S_TWR: begin
                ram_we    = r_keep && (c_m != r_id);
                ram_wdata = {r_id,
                             (c_b < r_sat) ? add_sat(c_b, r_cb, r_sat) : c_b,
                             (c_g < r_sat) ? add_sat(c_g, r_cg, r_sat) : c_g,
                             (c_r < r_sat) ? add_sat(c_r, r_cr, r_sat) : c_r};
                n_x     = r_x + 1'b1;
                n_state = S_TPIX;
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                if (r_keep) begin
                    n_res.read_red   = c_r;
                    n_res.read_green = c_g;
                    n_res.read_blue  = c_b;
                    n_res.read_mark  = c_m;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_clr_op <= 1'b0;
            r_ov     <= 1'b0;
            r_sat    <= SAT_RST;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_clr_op <= n_clr_op;
            r_ov     <= n_ov;
            if (cfg_wr && paddr == ADDR_SAT) begin
                r_sat <= pwdata[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;   r_res <= n_res;   r_op <= n_op;
        r_id <= n_id;     r_cr <= n_cr;     r_cg <= n_cg;   r_cb <= n_cb;
        r_reach <= n_reach; r_mx <= n_mx;   r_my <= n_my;
        r_x1 <= n_x1; r_y1 <= n_y1; r_x2 <= n_x2; r_y2 <= n_y2; r_x3 <= n_x3; r_y3 <= n_y3;
        r_d1 <= n_d1; r_d2 <= n_d2; r_d3 <= n_d3; r_dsel <= n_dsel;
        r_dnum <= n_dnum; r_dden <= n_dden;
        r_maj <= n_maj; r_end <= n_end; r_row <= n_row;
        r_xmaj <= n_xmaj; r_part <= n_part; r_keep <= n_keep;
        r_acc <= n_acc; r_xa <= n_xa; r_xb <= n_xb; r_hi <= n_hi;
        r_x <= n_x; r_addr <= n_addr;
    end

    mrbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    mrbe_ram #(
        .W     (PIX_W),
        .DEPTH (FB_DEPTH)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `MRBE_AST_IMP(a_we_states, ram_we,
        (r_state == S_CLR) || (r_state == S_LWR) || (r_state == S_TWR))
    `MRBE_AST_IMP(a_div_done_wait, div_done, r_state == S_DIVW)
    `MRBE_AST_NXT(a_accept_leaves_idle, in_acc, r_state != S_IDLE)
    `MRBE_AST_NXT(a_fin_loads, (r_state == S_FIN) && (!r_ov || o_out.ready),
        r_ov && (r_state == S_IDLE))
endmodule
